// ===== hdl/bitmap_page_allocator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define BPA_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define BPA_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== hdl/bpa_pkg.sv =====
package bpa_pkg;

	localparam int PAGE_DEPTH = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = PAGE_DEPTH / WORD_BITS;
	localparam int CHUNK      = 8;

	localparam int CNT_W   = 13;
	localparam int ADDR_W  = 48;
	localparam int PG_W    = 12;
	localparam int WA_W    = 6;
	localparam int BIT_W   = 6;
	localparam int CH_W    = 3;
	localparam int INFO_W  = 3;
	localparam int IDX_W   = ADDR_W - PAGE_SHIFT;
	localparam int DATA_W  = 64;
	localparam int PADDR_W = 5;
	localparam int FREED_W = 4;
	localparam int FLAG_W  = WORD_BITS * INFO_W;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(PAGE_DEPTH);

	localparam logic [INFO_W-1:0] INFO_ALLOC  = 3'b001;
	localparam logic [INFO_W-1:0] INFO_KERNEL = 3'b010;
	localparam logic [INFO_W-1:0] INFO_ZERO   = 3'b100;

	localparam logic [1:0] REG_TOTAL    = 2'd0;
	localparam logic [1:0] REG_RESERVED = 2'd1;
	localparam logic [1:0] REG_BASE     = 2'd2;

	localparam logic [CNT_W-1:0] RST_TOTAL    = 13'd4096;
	localparam logic [CNT_W-1:0] RST_RESERVED = 13'd64;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_QUERY = 2'd2,
		OP_INIT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_RANGE     = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_BAD_ARG      = 2'd3
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  reserved;
		logic [ADDR_W-1:0] base;
	} cfg_t;

	typedef enum logic [3:0] {
		DP_IDLE    = 4'd0,
		DP_ACCEPT  = 4'd1,
		DP_READ    = 4'd2,
		DP_SCAN    = 4'd3,
		DP_MARK_WR = 4'd4,
		DP_FREE    = 4'd5,
		DP_WB      = 4'd6,
		DP_QUERY   = 4'd7,
		DP_INIT_WR = 4'd8,
		DP_FINISH  = 4'd9
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic imm;
		logic scan_found;
		logic scan_end;
		logic word_end;
		logic mark_last;
		logic free_stop;
		logic free_done;
		logic init_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hdl/bpa_regs.sv =====
module bpa_regs
	import bpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic [1:0] sel;
	logic       wr;

	assign sel    = paddr[PADDR_W-1:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total    <= RST_TOTAL;
			cfg_q.reserved <= RST_RESERVED;
			cfg_q.base     <= '0;
		end else if (wr) begin
			unique case (sel)
				REG_TOTAL:    cfg_q.total    <= pwdata[CNT_W-1:0];
				REG_RESERVED: cfg_q.reserved <= pwdata[CNT_W-1:0];
				REG_BASE:     cfg_q.base     <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_TOTAL:    prdata = DATA_W'(cfg_q.total);
			REG_RESERVED: prdata = DATA_W'(cfg_q.reserved);
			REG_BASE:     prdata = DATA_W'(cfg_q.base);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hdl/bpa_ctrl.sv =====
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_DECODE  = 11'b000_0000_0010,
		S_READ    = 11'b000_0000_0100,
		S_SCAN    = 11'b000_0000_1000,
		S_MARK_RD = 11'b000_0001_0000,
		S_MARK_WR = 11'b000_0010_0000,
		S_FREE    = 11'b000_0100_0000,
		S_WB      = 11'b000_1000_0000,
		S_QUERY   = 11'b001_0000_0000,
		S_INIT    = 11'b010_0000_0000,
		S_FIN     = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = DP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = DP_ACCEPT;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.imm) begin
					state_d = S_FIN;
				end else if (stat.op == OP_INIT) begin
					state_d = S_INIT;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd = DP_READ;
				unique case (stat.op)
					OP_ALLOC: state_d = S_SCAN;
					OP_FREE:  state_d = S_FREE;
					OP_QUERY: state_d = S_QUERY;
					OP_INIT:  state_d = S_FIN;
					default:  state_d = S_FIN;
				endcase
			end
			S_SCAN: begin
				cmd = DP_SCAN;
				priority if (stat.scan_found) begin
					state_d = S_MARK_RD;
				end else if (stat.scan_end) begin
					state_d = S_FIN;
				end else if (stat.word_end) begin
					state_d = S_READ;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_MARK_RD: begin
				cmd     = DP_READ;
				state_d = S_MARK_WR;
			end
			S_MARK_WR: begin
				cmd     = DP_MARK_WR;
				state_d = stat.mark_last ? S_FIN : S_MARK_RD;
			end
			S_FREE: begin
				cmd = DP_FREE;
				if (stat.free_stop || stat.word_end) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd     = DP_WB;
				state_d = stat.free_done ? S_FIN : S_READ;
			end
			S_QUERY: begin
				cmd     = DP_QUERY;
				state_d = S_FIN;
			end
			S_INIT: begin
				cmd = DP_INIT_WR;
				if (stat.init_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd     = DP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hdl/bpa_dp.sv =====
module bpa_dp
	import bpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  cfg_t              cfg,
	input  logic [1:0]        op,
	input  logic [ADDR_W-1:0] page_address,
	input  logic [CNT_W-1:0]  page_count,
	input  logic              kernel_flag,
	input  logic              zero_flag,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] result_address,
	output logic              is_allocated,
	output logic [CNT_W-1:0]  free_count,
	output logic [CNT_W-1:0]  used_count
);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [FLAG_W-1:0]    flag_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic                 vld_rd_q;
	logic [WORD_BITS-1:0] rd_q;
	logic [FLAG_W-1:0]    rdf_q;

	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [INFO_W-1:0] info_q;
	status_t           status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              alloc_bit_q;
	logic [CNT_W-1:0]  p_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  run_q;
	logic [PG_W-1:0]   start_q;
	logic [PG_W-1:0]   end_q;
	logic [WA_W-1:0]   wa_q;
	logic [WORD_BITS-1:0] clr_q;
	logic [CNT_W-1:0]  rsve_q;
	logic [CNT_W-1:0]  fp_q;
	logic              imm_q;
	logic              free_done_q;

	logic              o_valid_q;
	status_t           o_status_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic              o_alloc_q;
	logic [CNT_W-1:0]  o_free_q;
	logic [CNT_W-1:0]  o_used_q;

	op_t               op_in;
	logic [CNT_W-1:0]  eff_total;
	logic [CNT_W-1:0]  rsv_eff;
	logic              below;
	logic [ADDR_W-1:0] offs;
	logic [IDX_W-1:0]  idx;
	logic              idx_oor;
	logic              imm_in;
	status_t           st_in;

	logic [WORD_BITS-1:0] word;
	logic [FLAG_W-1:0]    fword;

	logic [CNT_W-1:0] s_run;
	logic [PG_W-1:0]  s_start;
	logic             s_found;
	logic [CNT_W-1:0] s_page;
	logic             scan_end;
	logic [CNT_W-1:0] p_next;
	logic [CNT_W-1:0] end_full;

	logic [CNT_W-1:0]     f_rem;
	logic                 f_stop;
	status_t              f_err;
	logic [WORD_BITS-1:0] f_mask;
	logic [FREED_W-1:0]   f_freed;
	logic [CNT_W-1:0]     f_page;
	logic [CNT_W:0]       fp_sum;

	logic [WORD_BITS-1:0] m_mask;
	logic [FLAG_W-1:0]    m_flags;
	logic [WORD_BITS-1:0] i_mask;
	logic [FLAG_W-1:0]    i_flags;
	logic [FLAG_W-1:0]    w_flags;
	logic [PG_W-1:0]      pg;
	logic [CNT_W-1:0]     ipg;
	logic [CNT_W-1:0]     init_next;

	logic                 we;
	logic [WORD_BITS-1:0] wd;
	logic [FLAG_W-1:0]    wf;

	assign op_in     = op_t'(op);
	assign eff_total = (cfg.total > MAX_CNT) ? MAX_CNT : cfg.total;
	assign rsv_eff   = (cfg.reserved < eff_total) ? cfg.reserved : eff_total;
	assign below     = page_address < cfg.base;
	assign offs      = page_address - cfg.base;
	assign idx       = offs[ADDR_W-1:PAGE_SHIFT];
	assign idx_oor   = (|idx[IDX_W-1:CNT_W]) || (idx[CNT_W-1:0] >= eff_total);

	always_comb begin
		st_in = ST_OK;
		unique case (op_in)
			OP_ALLOC: begin
				imm_in = (page_count == '0) || (page_count > eff_total);
				if (page_count == '0) begin
					st_in = ST_BAD_ARG;
				end else if (page_count > eff_total) begin
					st_in = ST_NO_RANGE;
				end
			end
			OP_FREE: begin
				imm_in = below || (page_count == '0) || idx_oor;
				if (below) begin
					st_in = ST_BAD_ARG;
				end else if ((page_count != '0) && idx_oor) begin
					st_in = ST_BAD_ARG;
				end
			end
			OP_QUERY: begin
				imm_in = below || idx_oor;
				if (below || idx_oor) begin
					st_in = ST_BAD_ARG;
				end
			end
			OP_INIT: imm_in = (rsv_eff == '0);
			default: imm_in = 1'b1;
		endcase
	end

	assign word  = vld_rd_q ? rd_q : '0;
	assign fword = vld_rd_q ? rdf_q : '0;

	always_comb begin
		s_run   = run_q;
		s_start = start_q;
		s_found = 1'b0;
		s_page  = '0;
		for (int j = 0; j < CHUNK; j++) begin
			s_page = {p_q[CNT_W-1:CH_W], CH_W'(j)};
			if (!s_found && (s_page < eff_total)) begin
				if (!word[{p_q[BIT_W-1:CH_W], CH_W'(j)}]) begin
					if (s_run == '0) begin
						s_start = s_page[PG_W-1:0];
					end
					s_run = s_run + 1'b1;
					if (s_run == cnt_q) begin
						s_found = 1'b1;
					end
				end else begin
					s_run = '0;
				end
			end
		end
	end

	assign p_next   = p_q + CNT_W'(CHUNK);
	assign scan_end = !s_found && ({1'b0, p_next} >= {1'b0, eff_total});
	assign end_full = {1'b0, s_start} + cnt_q - 1'b1;

	always_comb begin
		f_rem   = rem_q;
		f_stop  = 1'b0;
		f_err   = ST_OK;
		f_mask  = '0;
		f_freed = '0;
		f_page  = '0;
		for (int j = 0; j < CHUNK; j++) begin
			f_page = {p_q[CNT_W-1:CH_W], CH_W'(j)};
			if ((CH_W'(j) >= p_q[CH_W-1:0]) && !f_stop) begin
				if (f_rem == '0) begin
					f_stop = 1'b1;
				end else if (f_page >= eff_total) begin
					f_stop = 1'b1;
					f_err  = ST_BAD_ARG;
				end else if (!word[{p_q[BIT_W-1:CH_W], CH_W'(j)}]) begin
					f_stop = 1'b1;
					f_err  = ST_ALREADY_FREE;
				end else begin
					f_mask[{p_q[BIT_W-1:CH_W], CH_W'(j)}] = 1'b1;
					f_freed = f_freed + 1'b1;
					f_rem   = f_rem - 1'b1;
				end
			end
		end
		if (f_rem == '0) begin
			f_stop = 1'b1;
		end
	end

	assign fp_sum = {1'b0, fp_q} + (CNT_W+1)'(f_freed);

	always_comb begin
		m_mask  = '0;
		m_flags = '0;
		i_mask  = '0;
		i_flags = '0;
		w_flags = '0;
		pg      = '0;
		ipg     = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			pg  = {wa_q, BIT_W'(b)};
			ipg = {1'b0, wa_q, BIT_W'(b)};
			m_mask[b] = (pg >= start_q) && (pg <= end_q);
			m_flags[b*INFO_W +: INFO_W] = m_mask[b] ? info_q : fword[b*INFO_W +: INFO_W];
			i_mask[b] = ipg < rsve_q;
			i_flags[b*INFO_W +: INFO_W] = i_mask[b] ? (INFO_ALLOC | INFO_KERNEL) : '0;
			w_flags[b*INFO_W +: INFO_W] = clr_q[b] ? '0 : fword[b*INFO_W +: INFO_W];
		end
	end

	assign init_next = {1'b0, wa_q, {BIT_W{1'b0}}} + CNT_W'(WORD_BITS);

	always_comb begin
		we = 1'b0;
		wd = word;
		wf = fword;
		unique case (cmd)
			DP_MARK_WR: begin
				we = 1'b1;
				wd = word | m_mask;
				wf = m_flags;
			end
			DP_WB: begin
				we = 1'b1;
				wd = word & ~clr_q;
				wf = w_flags;
			end
			DP_INIT_WR: begin
				we = 1'b1;
				wd = i_mask;
				wf = i_flags;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			map_mem[wa_q]  <= wd;
			flag_mem[wa_q] <= wf;
		end
		if (cmd == DP_READ) begin
			rd_q  <= map_mem[wa_q];
			rdf_q <= flag_mem[wa_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			vld_rd_q    <= 1'b0;
			fp_q        <= '0;
			imm_q       <= 1'b0;
			free_done_q <= 1'b0;
			o_valid_q   <= 1'b0;
		end else begin
			if (cmd == DP_ACCEPT && op_in == OP_INIT) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[wa_q] <= 1'b1;
			end
			if (cmd == DP_READ) begin
				vld_rd_q <= vld_q[wa_q];
			end
			if (cmd == DP_ACCEPT) begin
				imm_q       <= imm_in;
				free_done_q <= 1'b0;
				if (op_in == OP_INIT) begin
					fp_q <= eff_total - rsv_eff;
				end
			end
			if (cmd == DP_MARK_WR && stat.mark_last) begin
				fp_q <= (fp_q > cnt_q) ? fp_q - cnt_q : '0;
			end
			if (cmd == DP_FREE) begin
				fp_q        <= (fp_sum > (CNT_W+1)'(PAGE_DEPTH)) ? MAX_CNT : fp_sum[CNT_W-1:0];
				free_done_q <= f_stop;
			end
			if (cmd == DP_FINISH) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			DP_ACCEPT: begin
				op_q        <= op_in;
				cnt_q       <= page_count;
				info_q      <= INFO_ALLOC | (kernel_flag ? INFO_KERNEL : '0)
					| (zero_flag ? INFO_ZERO : '0);
				status_q    <= st_in;
				res_addr_q  <= '0;
				alloc_bit_q <= 1'b0;
				run_q       <= '0;
				start_q     <= '0;
				clr_q       <= '0;
				rem_q       <= page_count;
				rsve_q      <= rsv_eff;
				unique case (op_in)
					OP_ALLOC: begin
						p_q  <= '0;
						wa_q <= '0;
					end
					OP_FREE: begin
						p_q  <= {1'b0, idx[PG_W-1:0]};
						wa_q <= idx[PG_W-1:BIT_W];
					end
					OP_QUERY: begin
						p_q  <= {1'b0, idx[PG_W-1:0]};
						wa_q <= idx[PG_W-1:BIT_W];
					end
					OP_INIT: begin
						p_q  <= '0;
						wa_q <= '0;
					end
					default: ;
				endcase
			end
			DP_SCAN: begin
				priority if (s_found) begin
					start_q <= s_start;
					end_q   <= end_full[PG_W-1:0];
					wa_q    <= s_start[PG_W-1:BIT_W];
				end else if (scan_end) begin
					status_q <= ST_NO_RANGE;
				end else begin
					run_q   <= s_run;
					start_q <= s_start;
					p_q     <= p_next;
					wa_q    <= p_next[PG_W-1:BIT_W];
				end
			end
			DP_MARK_WR: begin
				wa_q <= wa_q + 1'b1;
				if (stat.mark_last) begin
					res_addr_q <= cfg.base + ADDR_W'({start_q, {PAGE_SHIFT{1'b0}}});
				end
			end
			DP_FREE: begin
				clr_q <= clr_q | f_mask;
				rem_q <= f_rem;
				p_q   <= {p_q[CNT_W-1:CH_W] + 1'b1, {CH_W{1'b0}}};
				if (f_err != ST_OK) begin
					status_q <= f_err;
				end
			end
			DP_WB: begin
				clr_q <= '0;
				wa_q  <= p_q[PG_W-1:BIT_W];
			end
			DP_QUERY: begin
				alloc_bit_q <= word[p_q[BIT_W-1:0]];
			end
			DP_INIT_WR: begin
				wa_q <= wa_q + 1'b1;
			end
			DP_FINISH: begin
				o_status_q <= status_q;
				o_addr_q   <= res_addr_q;
				o_alloc_q  <= alloc_bit_q;
				o_free_q   <= fp_q;
				o_used_q   <= (eff_total > fp_q) ? eff_total - fp_q : '0;
			end
			default: ;
		endcase
	end

	assign stat.op         = op_q;
	assign stat.imm        = imm_q;
	assign stat.scan_found = s_found;
	assign stat.scan_end   = scan_end;
	assign stat.word_end   = (p_q[BIT_W-1:CH_W] == '1);
	assign stat.mark_last  = (wa_q == end_q[PG_W-1:BIT_W]);
	assign stat.free_stop  = f_stop;
	assign stat.free_done  = free_done_q;
	assign stat.init_last  = (init_next >= rsve_q);
	assign stat.out_free   = !o_valid_q || out_ready;

	assign out_valid      = o_valid_q;
	assign status         = o_status_q;
	assign result_address = o_addr_q;
	assign is_allocated   = o_alloc_q;
	assign free_count     = o_free_q;
	assign used_count     = o_used_q;

endmodule

// ===== hdl/bitmap_page_allocator.sv =====
// Channel   Handshake                 Word
// input     in_valid / in_ready       op, page_address, page_count, kernel_flag, zero_flag
// output    out_valid / out_ready     status, result_address, is_allocated, free_count,
//                                     used_count
// config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One operation is in flight at a time; the map is held as 64 words of 64 pages in a
// single-port memory, and the free and alloc loops cover eight pages per cycle within a
// map word. Query reads the map word of its page; init writes only the map words holding
// reserved pages. Alloc scans map words until a free run is found or the map ends, then
// reads and writes back each word it marks; free clears pages and writes back each word.
// Reset leaves every page free and the free counter at zero; no clearing pass is needed.
// A result waiting in the output register holds the controller before its next result.
module bitmap_page_allocator
	import bpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [ADDR_W-1:0]  page_address,
	input  logic [CNT_W-1:0]   page_count,
	input  logic               kernel_flag,
	input  logic               zero_flag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [ADDR_W-1:0]  result_address,
	output logic               is_allocated,
	output logic [CNT_W-1:0]   free_count,
	output logic [CNT_W-1:0]   used_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	cfg_t     cfg;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg),
		.op             (op),
		.page_address   (page_address),
		.page_count     (page_count),
		.kernel_flag    (kernel_flag),
		.zero_flag      (zero_flag),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_address (result_address),
		.is_allocated   (is_allocated),
		.free_count     (free_count),
		.used_count     (used_count)
	);

endmodule

// ===== hdl/bpa_checker.sv =====
`include "bitmap_page_allocator_macros.svh"

module bpa_checker
	import bpa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [ADDR_W-1:0] result_address,
	input logic              is_allocated,
	input logic [CNT_W-1:0]  free_count
);

	`BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Second word taken while busy.")
	`BPA_ASSERT_NOW(a_alloc_bit_ok, out_valid && is_allocated, status == ST_OK, "Allocated bit with an error status.")
	`BPA_ASSERT_NOW(a_free_bound, out_valid, free_count <= MAX_CNT, "Free count beyond the map depth.")
	`BPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_address), "Result word dropped while stalled.")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

// ===== tb/tb_bitmap_page_allocator.sv =====
`timescale 1ns / 100ps

module tb_bitmap_page_allocator;
	import bpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

	typedef struct {
		status_t           st;
		logic [ADDR_W-1:0] addr;
		logic              alloc;
		logic [CNT_W-1:0]  free_cnt;
		logic [CNT_W-1:0]  used_cnt;
	} page_result_t;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		int                cnt;
	} page_range_t;

	class page_scoreboard;
		bit               page_used[PAGE_DEPTH];
		int               free_left;
		int               total_reg;
		int               reserved_reg;
		logic [ADDR_W-1:0] base_reg;
		page_result_t     pending[$];
		page_range_t      live[$];
		int               errors;

		function new();
			foreach (page_used[i]) page_used[i] = 0;
			free_left = 0;
			total_reg = 4096;
			reserved_reg = 64;
			base_reg = '0;
			errors = 0;
		endfunction

		function void note_word(op_t o, logic [ADDR_W-1:0] a, int cnt, bit kern, bit zero);
			page_result_t r;
			int eff, run, first, rsv;
			longint unsigned idx, p;
			bit found;
			eff = (total_reg > PAGE_DEPTH) ? PAGE_DEPTH : total_reg;
			r.st = ST_OK;
			r.addr = '0;
			r.alloc = 0;
			case (o)
				OP_ALLOC: begin
					if (cnt == 0) begin
						r.st = ST_BAD_ARG;
					end else begin
						run = 0;
						first = 0;
						found = 0;
						for (int i = 0; i < eff && !found; i++) begin
							if (!page_used[i]) begin
								if (run == 0) first = i;
								run++;
								if (run == cnt) found = 1;
							end else begin
								run = 0;
							end
						end
						if (!found) begin
							r.st = ST_NO_RANGE;
						end else begin
							for (int i = 0; i < cnt; i++) page_used[first + i] = 1;
							free_left = (free_left > cnt) ? free_left - cnt : 0;
							r.addr = (base_reg + (ADDR_W'(first) << PAGE_SHIFT)) & ADDR_MASK;
							live.push_back('{r.addr, cnt});
						end
					end
				end
				OP_FREE: begin
					if (a < base_reg) begin
						r.st = ST_BAD_ARG;
					end else begin
						idx = longint'((a - base_reg) >> PAGE_SHIFT);
						for (int i = 0; i < cnt; i++) begin
							p = idx + i;
							if (p >= eff) begin
								r.st = ST_BAD_ARG;
								break;
							end
							if (!page_used[p]) begin
								r.st = ST_ALREADY_FREE;
								break;
							end
							page_used[p] = 0;
							if (free_left < PAGE_DEPTH) free_left++;
						end
					end
				end
				OP_QUERY: begin
					idx = longint'((a - base_reg) >> PAGE_SHIFT);
					if (a < base_reg || idx >= eff) r.st = ST_BAD_ARG;
					else r.alloc = page_used[idx];
				end
				default: begin
					rsv = (reserved_reg < eff) ? reserved_reg : eff;
					foreach (page_used[i]) page_used[i] = (i < rsv);
					free_left = eff - rsv;
					live.delete();
				end
			endcase
			r.free_cnt = CNT_W'(free_left);
			r.used_cnt = CNT_W'((eff > free_left) ? eff - free_left : 0);
			pending.push_back(r);
		endfunction

		function void check_word(logic [1:0] st, logic [ADDR_W-1:0] a, logic al,
				logic [CNT_W-1:0] fc, logic [CNT_W-1:0] uc);
			page_result_t e;
			if (pending.size() == 0) begin
				$error("Result word arrived with none expected.");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (st !== e.st) begin
				$error("status: expected %0d, actual %0d", e.st, st);
				errors++;
			end
			if (a !== e.addr) begin
				$error("result_address: expected %h, actual %h", e.addr, a);
				errors++;
			end
			if (al !== e.alloc) begin
				$error("is_allocated: expected %0d, actual %0d", e.alloc, al);
				errors++;
			end
			if (fc !== e.free_cnt) begin
				$error("free_count: expected %0d, actual %0d", e.free_cnt, fc);
				errors++;
			end
			if (uc !== e.used_cnt) begin
				$error("used_count: expected %0d, actual %0d", e.used_cnt, uc);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         op = OP_QUERY;
	logic [ADDR_W-1:0]  page_address = '0;
	logic [CNT_W-1:0]   page_count = '0;
	logic               kernel_flag = 0;
	logic               zero_flag = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  result_address;
	logic               is_allocated;
	logic [CNT_W-1:0]   free_count;
	logic [CNT_W-1:0]   used_count;
	logic               psel = 0;
	logic               penable = 0;
	logic               pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	page_scoreboard sb = new();
	int idle_cycles = 0;
	int burst_left = 0;

	bitmap_page_allocator dut (.*);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if ($urandom_range(0, 99) < 3) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0) || ($time / 4000) % 3 == 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(status, result_address, is_allocated, free_count, used_count);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_word(op_t o, logic [ADDR_W-1:0] a, int cnt, bit kern, bit zero);
		@(negedge clk);
		op = o;
		page_address = a;
		page_count = CNT_W'(cnt);
		kernel_flag = kern;
		zero_flag = zero;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(o, a, cnt, kern, zero);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel = 1;
		pwrite = 1;
		penable = 0;
		paddr = PADDR_W'(idx) << 3;
		pwdata = val;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		case (idx)
			REG_TOTAL:    sb.total_reg = int'(val[CNT_W-1:0]);
			REG_RESERVED: sb.reserved_reg = int'(val[CNT_W-1:0]);
			default:      sb.base_reg = val[ADDR_W-1:0];
		endcase
	endtask

	task automatic set_config(int tot, int rsv, logic [ADDR_W-1:0] b);
		drain();
		write_reg(REG_TOTAL, DATA_W'(tot));
		write_reg(REG_RESERVED, DATA_W'(rsv));
		write_reg(REG_BASE, DATA_W'(b));
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		return ADDR_W'({$urandom, $urandom});
	endfunction

	function automatic logic [ADDR_W-1:0] page_at(int idx);
		return (sb.base_reg + (ADDR_W'(idx) << PAGE_SHIFT) + ADDR_W'($urandom_range(0, 4095)))
			& ADDR_MASK;
	endfunction

	function automatic int rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 12);
		if (r < 90) return $urandom_range(0, 200);
		return $urandom_range(0, 8191);
	endfunction

	task automatic random_word();
		int r, k, cnt, eff;
		page_range_t rg;
		eff = (sb.total_reg > PAGE_DEPTH) ? PAGE_DEPTH : sb.total_reg;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_word(OP_ALLOC, rand_addr(), rand_count(), 1'($urandom), 1'($urandom));
		end else if (r < 75) begin
			if (sb.live.size() != 0 && $urandom_range(0, 9) < 7) begin
				k = $urandom_range(0, sb.live.size() - 1);
				rg = sb.live[k];
				sb.live.delete(k);
				cnt = rg.cnt + $urandom_range(0, 2) - ($urandom_range(0, 3) == 0);
				send_word(OP_FREE, rg.addr | ADDR_W'($urandom_range(0, 4095)), cnt,
					1'($urandom), 1'($urandom));
			end else if ($urandom_range(0, 1)) begin
				send_word(OP_FREE, page_at($urandom_range(0, eff + 2)), rand_count(),
					1'($urandom), 1'($urandom));
			end else begin
				send_word(OP_FREE, rand_addr(), rand_count(), 1'($urandom), 1'($urandom));
			end
		end else if (r < 96) begin
			if ($urandom_range(0, 3) != 0)
				send_word(OP_QUERY, page_at($urandom_range(0, eff + 1)), $urandom,
					1'($urandom), 1'($urandom));
			else
				send_word(OP_QUERY, rand_addr(), $urandom, 1'($urandom), 1'($urandom));
		end else begin
			send_word(OP_INIT, rand_addr(), $urandom, 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Before init the free counter is zero, yet alloc still works on the map.
		send_word(OP_ALLOC, '0, 3, 1, 1);
		send_word(OP_QUERY, page_at(1), 0, 0, 0);
		send_word(OP_FREE, page_at(0), 0, 0, 0);
		send_word(OP_FREE, page_at(0), 5, 0, 0);
		send_word(OP_INIT, ADDR_MASK, 8191, 1, 1);
		send_word(OP_ALLOC, '0, 0, 0, 0);
		send_word(OP_ALLOC, '0, 4096, 0, 0);
		send_word(OP_ALLOC, '0, 8191, 1, 0);
		send_word(OP_ALLOC, '0, 4032, 0, 1);
		send_word(OP_QUERY, page_at(4095), 0, 0, 0);
		send_word(OP_QUERY, page_at(4096), 0, 0, 0);
		send_word(OP_QUERY, ADDR_MASK, 0, 0, 0);
		send_word(OP_FREE, page_at(4090), 10, 0, 0);
		send_word(OP_FREE, page_at(60), 8, 0, 0);
		send_word(OP_FREE, page_at(100), 4096, 0, 0);
		send_word(OP_ALLOC, '0, 1, 1, 1);

		set_config(100, 8, 48'h1234_5678_9000);
		send_word(OP_INIT, '0, 0, 0, 0);
		send_word(OP_FREE, 48'h1234_5678_8FFF, 1, 0, 0);
		send_word(OP_QUERY, 48'h0, 1, 0, 0);
		send_word(OP_ALLOC, '0, 92, 0, 0);
		send_word(OP_ALLOC, '0, 1, 0, 0);
		send_word(OP_FREE, page_at(8), 93, 0, 0);

		set_config(8191, 8191, ADDR_MASK);
		send_word(OP_INIT, '0, 0, 0, 0);
		send_word(OP_ALLOC, '0, 1, 0, 0);
		send_word(OP_QUERY, ADDR_MASK, 0, 0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(4096, 0, '0);
				1: set_config(0, 0, 48'hFFFF_FFFF_F000);
				2: set_config(64, 100, rand_addr());
				3: set_config(300, 4096, rand_addr() >> 8);
				4: set_config($urandom_range(1, 8191), $urandom_range(0, 300), rand_addr());
				default: set_config(4096, 64, 48'h8000_0000_0000);
			endcase
			send_word(OP_INIT, rand_addr(), $urandom, 1'($urandom), 1'($urandom));
			repeat (ph == 1 ? 25 : 100) random_word();
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_regs.sv
hdl/bpa_ctrl.sv
hdl/bpa_dp.sv
hdl/bitmap_page_allocator.sv
hdl/bpa_checker.sv
tb/tb_bitmap_page_allocator.sv
